// ----- rtl/core/segment_segment_intersection_core_assert.svh -----
// Assertion macros shared by the segment intersection core.
`ifndef SEGMENT_SEGMENT_INTERSECTION_CORE_ASSERT_SVH
`define SEGMENT_SEGMENT_INTERSECTION_CORE_ASSERT_SVH

// Implication checked on every rising clock edge outside of reset.
`define SSI_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequence is checked in the following clock cycle.
`define SSI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/ssi_pkg.sv -----
// Shared types and constants of the segment intersection core.
`timescale 1ns / 1ps
`default_nettype none

package ssi_pkg;

  // Default coordinate width; the core supports 4 to 31 bits.
  localparam int unsigned CoordWidthDefault = 16;

  // Sign of one cross product, reduced to what the decision needs.
  typedef struct packed {
    logic zero;
    logic neg;
  } ssi_sign_t;

  // Signs of the four orientation tests.
  typedef struct packed {
    ssi_sign_t p_end;    // P direction against Q end
    ssi_sign_t p_start;  // P direction against Q start
    ssi_sign_t q_end;    // Q direction against P end
    ssi_sign_t q_start;  // Q direction against P start
  } ssi_orient_t;

endpackage

`default_nettype wire

// ----- rtl/core/ssi_diff.sv -----
// First pipeline stage: direction vectors and endpoint differences.
`timescale 1ns / 1ps
`default_nettype none

module ssi_diff #(
  parameter int unsigned CoordWidth = ssi_pkg::CoordWidthDefault,
  localparam int unsigned DiffWidth = CoordWidth + 1
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         valid_i,
  output logic                              ready_o,
  input  wire logic signed [CoordWidth-1:0] px1_i,
  input  wire logic signed [CoordWidth-1:0] py1_i,
  input  wire logic signed [CoordWidth-1:0] px2_i,
  input  wire logic signed [CoordWidth-1:0] py2_i,
  input  wire logic signed [CoordWidth-1:0] qx1_i,
  input  wire logic signed [CoordWidth-1:0] qy1_i,
  input  wire logic signed [CoordWidth-1:0] qx2_i,
  input  wire logic signed [CoordWidth-1:0] qy2_i,
  output logic                              valid_o,
  input  wire logic                         ready_i,
  output logic signed [DiffWidth-1:0]       dpx_o,
  output logic signed [DiffWidth-1:0]       dpy_o,
  output logic signed [DiffWidth-1:0]       dqx_o,
  output logic signed [DiffWidth-1:0]       dqy_o,
  output logic signed [DiffWidth-1:0]       ex_o,
  output logic signed [DiffWidth-1:0]       ey_o,
  output logic signed [DiffWidth-1:0]       sx_o,
  output logic signed [DiffWidth-1:0]       sy_o,
  output logic signed [DiffWidth-1:0]       fx_o,
  output logic signed [DiffWidth-1:0]       fy_o,
  output logic signed [DiffWidth-1:0]       gx_o,
  output logic signed [DiffWidth-1:0]       gy_o,
  output logic                              degen_o
);

  function automatic logic signed [DiffWidth-1:0] diff_of(
    input logic signed [CoordWidth-1:0] a,
    input logic signed [CoordWidth-1:0] b
  );
    diff_of = DiffWidth'(a) - DiffWidth'(b);
  endfunction

  logic                        valid_q;
  logic                        load;
  logic signed [DiffWidth-1:0] dpx_d, dpy_d, dqx_d, dqy_d;
  logic signed [DiffWidth-1:0] dpx_q, dpy_q, dqx_q, dqy_q;
  logic signed [DiffWidth-1:0] ex_q, ey_q, sx_q, sy_q, fx_q, fy_q, gx_q, gy_q;
  logic                        degen_q;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  assign dpx_d = diff_of(px2_i, px1_i);
  assign dpy_d = diff_of(py2_i, py1_i);
  assign dqx_d = diff_of(qx2_i, qx1_i);
  assign dqy_d = diff_of(qy2_i, qy1_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      dpx_q   <= dpx_d;
      dpy_q   <= dpy_d;
      dqx_q   <= dqx_d;
      dqy_q   <= dqy_d;
      ex_q    <= diff_of(qx2_i, px1_i);
      ey_q    <= diff_of(qy2_i, py1_i);
      sx_q    <= diff_of(qx1_i, px1_i);
      sy_q    <= diff_of(qy1_i, py1_i);
      fx_q    <= diff_of(px2_i, qx1_i);
      fy_q    <= diff_of(py2_i, qy1_i);
      gx_q    <= diff_of(px1_i, qx1_i);
      gy_q    <= diff_of(py1_i, qy1_i);
      degen_q <= ((dpx_d == '0) && (dpy_d == '0)) || ((dqx_d == '0) && (dqy_d == '0));
    end
  end

  assign valid_o = valid_q;
  assign dpx_o   = dpx_q;
  assign dpy_o   = dpy_q;
  assign dqx_o   = dqx_q;
  assign dqy_o   = dqy_q;
  assign ex_o    = ex_q;
  assign ey_o    = ey_q;
  assign sx_o    = sx_q;
  assign sy_o    = sy_q;
  assign fx_o    = fx_q;
  assign fy_o    = fy_q;
  assign gx_o    = gx_q;
  assign gy_o    = gy_q;
  assign degen_o = degen_q;

endmodule

`default_nettype wire

// ----- rtl/core/ssi_mult.sv -----
// Second pipeline stage: the products of all cross and dot terms.
`timescale 1ns / 1ps
`default_nettype none

module ssi_mult #(
  parameter int unsigned CoordWidth = ssi_pkg::CoordWidthDefault,
  localparam int unsigned DiffWidth = CoordWidth + 1,
  localparam int unsigned ProdWidth = 2 * DiffWidth
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        valid_i,
  output logic                             ready_o,
  input  wire logic signed [DiffWidth-1:0] dpx_i,
  input  wire logic signed [DiffWidth-1:0] dpy_i,
  input  wire logic signed [DiffWidth-1:0] dqx_i,
  input  wire logic signed [DiffWidth-1:0] dqy_i,
  input  wire logic signed [DiffWidth-1:0] ex_i,
  input  wire logic signed [DiffWidth-1:0] ey_i,
  input  wire logic signed [DiffWidth-1:0] sx_i,
  input  wire logic signed [DiffWidth-1:0] sy_i,
  input  wire logic signed [DiffWidth-1:0] fx_i,
  input  wire logic signed [DiffWidth-1:0] fy_i,
  input  wire logic signed [DiffWidth-1:0] gx_i,
  input  wire logic signed [DiffWidth-1:0] gy_i,
  input  wire logic                        degen_i,
  output logic                             valid_o,
  input  wire logic                        ready_i,
  // Cross product terms: each cross is the first product minus the second.
  output logic signed [ProdWidth-1:0]      pe_a_o,
  output logic signed [ProdWidth-1:0]      pe_b_o,
  output logic signed [ProdWidth-1:0]      ps_a_o,
  output logic signed [ProdWidth-1:0]      ps_b_o,
  output logic signed [ProdWidth-1:0]      qe_a_o,
  output logic signed [ProdWidth-1:0]      qe_b_o,
  output logic signed [ProdWidth-1:0]      qs_a_o,
  output logic signed [ProdWidth-1:0]      qs_b_o,
  // Dot product terms: each dot is the sum of its two products.
  output logic signed [ProdWidth-1:0]      len_a_o,
  output logic signed [ProdWidth-1:0]      len_b_o,
  output logic signed [ProdWidth-1:0]      ds_a_o,
  output logic signed [ProdWidth-1:0]      ds_b_o,
  output logic signed [ProdWidth-1:0]      de_a_o,
  output logic signed [ProdWidth-1:0]      de_b_o,
  output logic                             degen_o
);

  logic                        valid_q;
  logic                        load;
  logic signed [ProdWidth-1:0] pe_a_q, pe_b_q, ps_a_q, ps_b_q;
  logic signed [ProdWidth-1:0] qe_a_q, qe_b_q, qs_a_q, qs_b_q;
  logic signed [ProdWidth-1:0] len_a_q, len_b_q, ds_a_q, ds_b_q, de_a_q, de_b_q;
  logic                        degen_q;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      pe_a_q  <= dpx_i * ey_i;
      pe_b_q  <= dpy_i * ex_i;
      ps_a_q  <= dpx_i * sy_i;
      ps_b_q  <= dpy_i * sx_i;
      qe_a_q  <= dqx_i * fy_i;
      qe_b_q  <= dqy_i * fx_i;
      qs_a_q  <= dqx_i * gy_i;
      qs_b_q  <= dqy_i * gx_i;
      len_a_q <= dpx_i * dpx_i;
      len_b_q <= dpy_i * dpy_i;
      ds_a_q  <= dpx_i * sx_i;
      ds_b_q  <= dpy_i * sy_i;
      de_a_q  <= dpx_i * ex_i;
      de_b_q  <= dpy_i * ey_i;
      degen_q <= degen_i;
    end
  end

  assign valid_o = valid_q;
  assign pe_a_o  = pe_a_q;
  assign pe_b_o  = pe_b_q;
  assign ps_a_o  = ps_a_q;
  assign ps_b_o  = ps_b_q;
  assign qe_a_o  = qe_a_q;
  assign qe_b_o  = qe_b_q;
  assign qs_a_o  = qs_a_q;
  assign qs_b_o  = qs_b_q;
  assign len_a_o = len_a_q;
  assign len_b_o = len_b_q;
  assign ds_a_o  = ds_a_q;
  assign ds_b_o  = ds_b_q;
  assign de_a_o  = de_a_q;
  assign de_b_o  = de_b_q;
  assign degen_o = degen_q;

endmodule

`default_nettype wire

// ----- rtl/core/ssi_combine.sv -----
// Third pipeline stage: cross product signs and projection sums.
`timescale 1ns / 1ps
`default_nettype none

module ssi_combine #(
  parameter int unsigned CoordWidth = ssi_pkg::CoordWidthDefault,
  localparam int unsigned DiffWidth = CoordWidth + 1,
  localparam int unsigned ProdWidth = 2 * DiffWidth,
  localparam int unsigned SumWidth  = ProdWidth + 1
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        valid_i,
  output logic                             ready_o,
  input  wire logic signed [ProdWidth-1:0] pe_a_i,
  input  wire logic signed [ProdWidth-1:0] pe_b_i,
  input  wire logic signed [ProdWidth-1:0] ps_a_i,
  input  wire logic signed [ProdWidth-1:0] ps_b_i,
  input  wire logic signed [ProdWidth-1:0] qe_a_i,
  input  wire logic signed [ProdWidth-1:0] qe_b_i,
  input  wire logic signed [ProdWidth-1:0] qs_a_i,
  input  wire logic signed [ProdWidth-1:0] qs_b_i,
  input  wire logic signed [ProdWidth-1:0] len_a_i,
  input  wire logic signed [ProdWidth-1:0] len_b_i,
  input  wire logic signed [ProdWidth-1:0] ds_a_i,
  input  wire logic signed [ProdWidth-1:0] ds_b_i,
  input  wire logic signed [ProdWidth-1:0] de_a_i,
  input  wire logic signed [ProdWidth-1:0] de_b_i,
  input  wire logic                        degen_i,
  output logic                             valid_o,
  input  wire logic                        ready_i,
  output ssi_pkg::ssi_orient_t             orient_o,
  output logic signed [SumWidth-1:0]       len_o,
  output logic signed [SumWidth-1:0]       proj_start_o,
  output logic signed [SumWidth-1:0]       proj_end_o,
  output logic                             degen_o
);

  function automatic ssi_pkg::ssi_sign_t sign_of_cross(
    input logic signed [ProdWidth-1:0] a,
    input logic signed [ProdWidth-1:0] b
  );
    logic signed [SumWidth-1:0] c;
    c = SumWidth'(a) - SumWidth'(b);
    sign_of_cross.zero = (c == '0);
    sign_of_cross.neg  = c[SumWidth-1];
  endfunction

  logic                       valid_q;
  logic                       load;
  ssi_pkg::ssi_orient_t       orient_q;
  logic signed [SumWidth-1:0] len_q, proj_start_q, proj_end_q;
  logic                       degen_q;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      orient_q.p_end   <= sign_of_cross(pe_a_i, pe_b_i);
      orient_q.p_start <= sign_of_cross(ps_a_i, ps_b_i);
      orient_q.q_end   <= sign_of_cross(qe_a_i, qe_b_i);
      orient_q.q_start <= sign_of_cross(qs_a_i, qs_b_i);
      len_q            <= SumWidth'(len_a_i) + SumWidth'(len_b_i);
      proj_start_q     <= SumWidth'(ds_a_i) + SumWidth'(ds_b_i);
      proj_end_q       <= SumWidth'(de_a_i) + SumWidth'(de_b_i);
      degen_q          <= degen_i;
    end
  end

  assign valid_o      = valid_q;
  assign orient_o     = orient_q;
  assign len_o        = len_q;
  assign proj_start_o = proj_start_q;
  assign proj_end_o   = proj_end_q;
  assign degen_o      = degen_q;

endmodule

`default_nettype wire

// ----- rtl/core/ssi_decide.sv -----
// Final pipeline stage: intersection decision and the output register.
`timescale 1ns / 1ps
`default_nettype none

module ssi_decide #(
  parameter int unsigned CoordWidth = ssi_pkg::CoordWidthDefault,
  localparam int unsigned SumWidth  = 2 * (CoordWidth + 1) + 1
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       valid_i,
  output logic                            ready_o,
  input  wire ssi_pkg::ssi_orient_t       orient_i,
  input  wire logic signed [SumWidth-1:0] len_i,
  input  wire logic signed [SumWidth-1:0] proj_start_i,
  input  wire logic signed [SumWidth-1:0] proj_end_i,
  input  wire logic                       degen_i,
  output logic                            valid_o,
  input  wire logic                       ready_i,
  output logic                            intersects_o,
  output logic                            collinear_o,
  output logic                            degenerate_o
);

  logic valid_q;
  logic load;
  logic coll;
  logic overlap;
  logic p_same;
  logic q_same;
  logic hit_d, coll_d;
  logic hit_q, coll_q, degen_q;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  assign coll = (orient_i.p_end.zero && orient_i.p_start.zero)
             || (orient_i.q_end.zero && orient_i.q_start.zero);

  // Closed intervals overlap when the upper projection reaches zero and the
  // lower one stays within the length of P; min and max split into ORs.
  assign overlap = (!proj_start_i[SumWidth-1] || !proj_end_i[SumWidth-1])
                && ((proj_start_i <= len_i) || (proj_end_i <= len_i));

  assign p_same = (orient_i.p_end == orient_i.p_start);
  assign q_same = (orient_i.q_end == orient_i.q_start);

  always_comb begin
    hit_d  = 1'b0;
    coll_d = 1'b0;
    if (!degen_i) begin
      coll_d = coll;
      hit_d  = coll ? overlap : !(p_same || q_same);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      hit_q   <= hit_d;
      coll_q  <= coll_d;
      degen_q <= degen_i;
    end
  end

  assign valid_o      = valid_q;
  assign intersects_o = hit_q;
  assign collinear_o  = coll_q;
  assign degenerate_o = degen_q;

endmodule

`default_nettype wire

// ----- rtl/core/segment_segment_intersection_core.sv -----
// Top level of the pipelined segment pair intersection core.
//
// The input channel carries one transaction per segment pair: the start and
// end points of segment P (first_*) and of segment Q (second_*), each a
// two's complement coordinate of CoordWidth bits. The output channel
// carries one transaction per pair with three flags: intersects (the
// segments share a point, touching included), collinear (both lie on one
// line) and degenerate (either segment has zero length, which forces the
// other two flags low).
// The core is a four stage pipeline: differences, products, sums and signs,
// then the decision into the output register. A result is offered after its
// transaction has passed every stage register; while the receiver is ready,
// one transaction per cycle is sustained in both directions.
// Each stage holds its own valid bit and loads whenever it is empty or its
// successor takes its contents, so a stalled receiver backs the pipeline up
// stage by stage without losing or repeating a transaction; up to four
// transactions are held in flight.
// Reset clears all valid bits; the data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

`include "segment_segment_intersection_core_assert.svh"

module segment_segment_intersection_core #(
  parameter int unsigned CoordWidth = ssi_pkg::CoordWidthDefault
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic signed [CoordWidth-1:0] first_start_x_i,
  input  wire logic signed [CoordWidth-1:0] first_start_y_i,
  input  wire logic signed [CoordWidth-1:0] first_end_x_i,
  input  wire logic signed [CoordWidth-1:0] first_end_y_i,
  input  wire logic signed [CoordWidth-1:0] second_start_x_i,
  input  wire logic signed [CoordWidth-1:0] second_start_y_i,
  input  wire logic signed [CoordWidth-1:0] second_end_x_i,
  input  wire logic signed [CoordWidth-1:0] second_end_y_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic                              intersects_o,
  output logic                              collinear_o,
  output logic                              degenerate_o
);

  localparam int unsigned DiffWidth = CoordWidth + 1;
  localparam int unsigned ProdWidth = 2 * DiffWidth;
  localparam int unsigned SumWidth  = ProdWidth + 1;

  // Stage 1 to stage 2: direction vectors and endpoint differences.
  logic                        s1_valid, s1_ready;
  logic signed [DiffWidth-1:0] dpx, dpy, dqx, dqy;
  logic signed [DiffWidth-1:0] ex, ey, sx, sy, fx, fy, gx, gy;
  logic                        s1_degen;

  // Stage 2 to stage 3: registered products.
  logic                        s2_valid, s2_ready;
  logic signed [ProdWidth-1:0] pe_a, pe_b, ps_a, ps_b, qe_a, qe_b, qs_a, qs_b;
  logic signed [ProdWidth-1:0] len_a, len_b, ds_a, ds_b, de_a, de_b;
  logic                        s2_degen;

  // Stage 3 to stage 4: orientation signs and projections onto P.
  logic                        s3_valid, s3_ready;
  ssi_pkg::ssi_orient_t        orient;
  logic signed [SumWidth-1:0]  len, proj_start, proj_end;
  logic                        s3_degen;

  ssi_diff #(
    .CoordWidth(CoordWidth)
  ) u_diff (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .px1_i   (first_start_x_i),
    .py1_i   (first_start_y_i),
    .px2_i   (first_end_x_i),
    .py2_i   (first_end_y_i),
    .qx1_i   (second_start_x_i),
    .qy1_i   (second_start_y_i),
    .qx2_i   (second_end_x_i),
    .qy2_i   (second_end_y_i),
    .valid_o (s1_valid),
    .ready_i (s1_ready),
    .dpx_o   (dpx),
    .dpy_o   (dpy),
    .dqx_o   (dqx),
    .dqy_o   (dqy),
    .ex_o    (ex),
    .ey_o    (ey),
    .sx_o    (sx),
    .sy_o    (sy),
    .fx_o    (fx),
    .fy_o    (fy),
    .gx_o    (gx),
    .gy_o    (gy),
    .degen_o (s1_degen)
  );

  ssi_mult #(
    .CoordWidth(CoordWidth)
  ) u_mult (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .dpx_i   (dpx),
    .dpy_i   (dpy),
    .dqx_i   (dqx),
    .dqy_i   (dqy),
    .ex_i    (ex),
    .ey_i    (ey),
    .sx_i    (sx),
    .sy_i    (sy),
    .fx_i    (fx),
    .fy_i    (fy),
    .gx_i    (gx),
    .gy_i    (gy),
    .degen_i (s1_degen),
    .valid_o (s2_valid),
    .ready_i (s2_ready),
    .pe_a_o  (pe_a),
    .pe_b_o  (pe_b),
    .ps_a_o  (ps_a),
    .ps_b_o  (ps_b),
    .qe_a_o  (qe_a),
    .qe_b_o  (qe_b),
    .qs_a_o  (qs_a),
    .qs_b_o  (qs_b),
    .len_a_o (len_a),
    .len_b_o (len_b),
    .ds_a_o  (ds_a),
    .ds_b_o  (ds_b),
    .de_a_o  (de_a),
    .de_b_o  (de_b),
    .degen_o (s2_degen)
  );

  ssi_combine #(
    .CoordWidth(CoordWidth)
  ) u_combine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (s2_valid),
    .ready_o      (s2_ready),
    .pe_a_i       (pe_a),
    .pe_b_i       (pe_b),
    .ps_a_i       (ps_a),
    .ps_b_i       (ps_b),
    .qe_a_i       (qe_a),
    .qe_b_i       (qe_b),
    .qs_a_i       (qs_a),
    .qs_b_i       (qs_b),
    .len_a_i      (len_a),
    .len_b_i      (len_b),
    .ds_a_i       (ds_a),
    .ds_b_i       (ds_b),
    .de_a_i       (de_a),
    .de_b_i       (de_b),
    .degen_i      (s2_degen),
    .valid_o      (s3_valid),
    .ready_i      (s3_ready),
    .orient_o     (orient),
    .len_o        (len),
    .proj_start_o (proj_start),
    .proj_end_o   (proj_end),
    .degen_o      (s3_degen)
  );

  ssi_decide #(
    .CoordWidth(CoordWidth)
  ) u_decide (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (s3_valid),
    .ready_o      (s3_ready),
    .orient_i     (orient),
    .len_i        (len),
    .proj_start_i (proj_start),
    .proj_end_i   (proj_end),
    .degen_i      (s3_degen),
    .valid_o      (out_valid_o),
    .ready_i      (out_ready_i),
    .intersects_o (intersects_o),
    .collinear_o  (collinear_o),
    .degenerate_o (degenerate_o)
  );

  // A zero-length segment never reports a hit or a common line.
  `SSI_ASSERT_IMPLIES(a_degen_excl, clk_i, rst_ni, out_valid_o && degenerate_o, !intersects_o && !collinear_o, "degenerate result carries other flags")

  // With the receiver ready, every stage drains, so the input is never blocked.
  `SSI_ASSERT_IMPLIES(a_no_stall_ready, clk_i, rst_ni, out_ready_i, in_ready_o, "input blocked although the output is ready")

  // A result appears only when the stage before the output held a transaction.
  `SSI_ASSERT_NEXT(a_out_from_s3, clk_i, rst_ni, !out_valid_o && !s3_valid, !out_valid_o, "output valid without a transaction in flight")

  // The third stage fills only from the second.
  `SSI_ASSERT_NEXT(a_s3_from_s2, clk_i, rst_ni, !s3_valid && !s2_valid, !s3_valid, "third stage valid without a source")

endmodule

`default_nettype wire
